>>> hdl/lpci_pkg.sv
// shared constants and types for the luma-preserving color inversion pipeline
package lpci_pkg;

	// default channel width
	localparam int unsigned CHANNEL_BITS_DEF = 8;

	// number of color lanes (red, green, blue)
	localparam int unsigned NUM_LANES = 3;

	// per-pixel mode bits that travel with each beat
	typedef struct packed {
		logic bypass;
		logic grey;
	} mode_t;

endpackage

>>> hdl/lpci_front.sv
// front stages: channel sort and sum, region test, numerator and denominator select
module lpci_front import lpci_pkg::*; #(
	parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   adv,
	input  logic                                   vld_i,
	input  logic                                   en_i,
	input  logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] ch_i,
	input  logic [CHANNEL_BITS-1:0]                alpha_i,
	output logic                                   vld_o,
	output logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] ch_o,
	output logic [CHANNEL_BITS-1:0]                alpha_o,
	output mode_t                                  mode_o,
	output logic [CHANNEL_BITS+1:0]                num_o,
	output logic [CHANNEL_BITS+1:0]                den_o,
	output logic [CHANNEL_BITS+1:0]                inv_o,
	output logic signed [CHANNEL_BITS+2:0]         c3_o [NUM_LANES]
);

	localparam int unsigned W  = CHANNEL_BITS;
	localparam int unsigned SW = W + 2;
	localparam int unsigned CW = W + 3;
	localparam int unsigned PW = 2 * W + 4;
	localparam logic [W-1:0]  CMAX = '1;
	localparam logic [SW-1:0] M3   = SW'({CMAX, 1'b0}) + SW'(CMAX);

	// stage 1: largest, smallest and sum
	logic [W-1:0]  hi_d, lo_d;
	logic [SW-1:0] s_d;
	logic          vld_s1;
	logic [NUM_LANES-1:0][W-1:0] ch_s1;
	logic [W-1:0]  alpha_s1, hi_s1, lo_s1;
	logic [SW-1:0] s_s1;
	mode_t         mode_s1;

	always_comb begin
		hi_d = ch_i[0];
		lo_d = ch_i[0];
		for (int i = 1; i < NUM_LANES; i++) begin
			if (ch_i[i] > hi_d) begin
				hi_d = ch_i[i];
			end
			if (ch_i[i] < lo_d) begin
				lo_d = ch_i[i];
			end
		end
		s_d = SW'(ch_i[0]) + SW'(ch_i[1]) + SW'(ch_i[2]);
	end

	// stage 2: region products
	logic [SW-1:0]          l3_d, h3_d;
	logic signed [W:0]      dlh_d;
	logic signed [CW-1:0]   ld_d, hd_d;
	logic signed [PW-1:0]   pa_d, ma_d, mb_d;
	logic                   vld_s2;
	logic [NUM_LANES-1:0][W-1:0] ch_s2;
	logic [W-1:0]           alpha_s2;
	logic [SW-1:0]          s_s2, l3_s2, h3_s2;
	logic signed [PW-1:0]   pa_s2, ma_s2, mb_s2;
	mode_t                  mode_s2;

	always_comb begin
		l3_d  = SW'(lo_s1) + SW'({lo_s1, 1'b0});
		h3_d  = SW'(hi_s1) + SW'({hi_s1, 1'b0});
		dlh_d = $signed({1'b0, lo_s1}) - $signed({1'b0, hi_s1});
		ld_d  = $signed({1'b0, l3_d}) - $signed({1'b0, s_s1});
		hd_d  = $signed({1'b0, h3_d}) - $signed({1'b0, s_s1});
		pa_d  = $signed({1'b0, s_s1}) * dlh_d;
		ma_d  = ld_d * $signed({1'b0, CMAX});
		mb_d  = hd_d * $signed({1'b0, CMAX});
	end

	// stage 3: select numerator and denominator, per-lane linear terms
	logic                 ca_d, cb_d;
	logic [SW-1:0]        num_d, den_d;
	logic [SW-1:0]        c3u_d [NUM_LANES];
	logic signed [CW-1:0] c3_d  [NUM_LANES];

	always_comb begin
		ca_d = pa_s2 < ma_s2;
		cb_d = (-pa_s2) < mb_s2;
		if (ca_d && cb_d) begin
			num_d = s_s2;
			den_d = M3 - s_s2;
		end else if (ca_d) begin
			num_d = h3_s2 - s_s2;
			den_d = s_s2 - l3_s2;
		end else if (cb_d) begin
			num_d = s_s2 - l3_s2;
			den_d = h3_s2 - s_s2;
		end else begin
			num_d = M3 - s_s2;
			den_d = s_s2;
		end
		for (int i = 0; i < NUM_LANES; i++) begin
			c3u_d[i] = SW'(ch_s2[i]) + SW'({ch_s2[i], 1'b0});
			c3_d[i]  = $signed({1'b0, c3u_d[i]}) - $signed({1'b0, s_s2});
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_o  <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_o  <= vld_s2;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s1          <= ch_i;
			alpha_s1       <= alpha_i;
			hi_s1          <= hi_d;
			lo_s1          <= lo_d;
			s_s1           <= s_d;
			mode_s1.bypass <= !en_i;
			mode_s1.grey   <= hi_d == lo_d;

			ch_s2    <= ch_s1;
			alpha_s2 <= alpha_s1;
			s_s2     <= s_s1;
			l3_s2    <= l3_d;
			h3_s2    <= h3_d;
			pa_s2    <= pa_d;
			ma_s2    <= ma_d;
			mb_s2    <= mb_d;
			mode_s2  <= mode_s1;

			ch_o    <= ch_s2;
			alpha_o <= alpha_s2;
			mode_o  <= mode_s2;
			num_o   <= num_d;
			den_o   <= den_d;
			inv_o   <= M3 - s_s2;
			for (int i = 0; i < NUM_LANES; i++) begin
				c3_o[i] <= c3_d[i];
			end
		end
	end

endmodule

>>> hdl/lpci_mix.sv
// mix stages: weighted numerator per lane, then divider operands
module lpci_mix import lpci_pkg::*; #(
	parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   adv,
	input  logic                                   vld_i,
	input  logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] ch_i,
	input  logic [CHANNEL_BITS-1:0]                alpha_i,
	input  mode_t                                  mode_i,
	input  logic [CHANNEL_BITS+1:0]                num_i,
	input  logic [CHANNEL_BITS+1:0]                den_i,
	input  logic [CHANNEL_BITS+1:0]                inv_i,
	input  logic signed [CHANNEL_BITS+2:0]         c3_i [NUM_LANES],
	output logic                                   vld_o,
	output logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] ch_o,
	output logic [CHANNEL_BITS-1:0]                alpha_o,
	output mode_t                                  mode_o,
	output logic [2*CHANNEL_BITS+6:0]              x_o [NUM_LANES],
	output logic [CHANNEL_BITS+4:0]                y_o,
	output logic [NUM_LANES-1:0]                   neg_o
);

	localparam int unsigned W   = CHANNEL_BITS;
	localparam int unsigned SW  = W + 2;
	localparam int unsigned CW  = W + 3;
	localparam int unsigned P2W = CW + SW + 1;
	localparam int unsigned NW  = 2 * W + 7;
	localparam int unsigned XW  = 2 * W + 7;
	localparam int unsigned YW  = W + 5;

	// stage 4: products
	logic [2*SW-1:0]       p1_d;
	logic signed [P2W-1:0] p2_d [NUM_LANES];
	logic                  vld_s4;
	logic [NUM_LANES-1:0][W-1:0] ch_s4;
	logic [W-1:0]          alpha_s4;
	mode_t                 mode_s4;
	logic [SW-1:0]         den_s4;
	logic [2*SW-1:0]       p1_s4;
	logic signed [P2W-1:0] p2_s4 [NUM_LANES];

	always_comb begin
		p1_d = inv_i * den_i;
		for (int i = 0; i < NUM_LANES; i++) begin
			p2_d[i] = c3_i[i] * $signed({1'b0, num_i});
		end
	end

	// stage 5: sum, rounding offset and divisor
	logic signed [NW-1:0] n_d [NUM_LANES];
	logic [XW-1:0]        x_d [NUM_LANES];
	logic [W+3:0]         den3_d;
	logic [YW-1:0]        y_d;

	always_comb begin
		den3_d = (W+4)'(den_s4) + (W+4)'({den_s4, 1'b0});
		y_d    = YW'({den_s4, 2'b0}) + YW'({den_s4, 1'b0});
		for (int i = 0; i < NUM_LANES; i++) begin
			n_d[i] = $signed({1'b0, p1_s4}) + p2_s4[i];
			x_d[i] = {n_d[i][XW-2:0], 1'b0} + XW'(den3_d);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_o  <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_i;
			vld_o  <= vld_s4;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s4    <= ch_i;
			alpha_s4 <= alpha_i;
			mode_s4  <= mode_i;
			den_s4   <= den_i;
			p1_s4    <= p1_d;
			ch_o     <= ch_s4;
			alpha_o  <= alpha_s4;
			mode_o   <= mode_s4;
			y_o      <= y_d;
			for (int i = 0; i < NUM_LANES; i++) begin
				p2_s4[i] <= p2_d[i];
				x_o[i]   <= x_d[i];
				neg_o[i] <= n_d[i][NW-1];
			end
		end
	end

endmodule

>>> hdl/lpci_div.sv
// pipelined restoring divider, one quotient bit per stage, three lanes sharing a divisor
module lpci_div import lpci_pkg::*; #(
	parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   adv,
	input  logic                                   vld_i,
	input  logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] ch_i,
	input  logic [CHANNEL_BITS-1:0]                alpha_i,
	input  mode_t                                  mode_i,
	input  logic [2*CHANNEL_BITS+6:0]              x_i [NUM_LANES],
	input  logic [CHANNEL_BITS+4:0]                y_i,
	input  logic [NUM_LANES-1:0]                   neg_i,
	output logic                                   vld_o,
	output logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] ch_o,
	output logic [CHANNEL_BITS-1:0]                alpha_o,
	output mode_t                                  mode_o,
	output logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] q_o,
	output logic [NUM_LANES-1:0]                   neg_o,
	output logic [NUM_LANES-1:0]                   ovf_o
);

	localparam int unsigned W  = CHANNEL_BITS;
	localparam int unsigned XW = 2 * W + 7;
	localparam int unsigned YW = W + 5;

	// stage 0 checks for a quotient beyond the channel range, stages 1..W make one bit each
	logic                        vld_s   [W+1];
	logic [XW-1:0]               rem_s   [W+1][NUM_LANES];
	logic [YW-1:0]               y_s     [W+1];
	logic [NUM_LANES-1:0][W-1:0] q_s     [W+1];
	logic [NUM_LANES-1:0]        neg_s   [W+1];
	logic [NUM_LANES-1:0]        ovf_s   [W+1];
	logic [NUM_LANES-1:0][W-1:0] ch_s    [W+1];
	logic [W-1:0]                alpha_s [W+1];
	mode_t                       mode_s  [W+1];

	// range check stage
	logic [NUM_LANES-1:0] ovf_d;
	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			ovf_d[i] = x_i[i] >= (XW'(y_i) << W);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				rem_s[0][i] <= x_i[i];
			end
			y_s[0]     <= y_i;
			q_s[0]     <= '0;
			neg_s[0]   <= neg_i;
			ovf_s[0]   <= ovf_d;
			ch_s[0]    <= ch_i;
			alpha_s[0] <= alpha_i;
			mode_s[0]  <= mode_i;
		end
	end

	// quotient bit stages, most significant bit first
	for (genvar j = 1; j <= W; j++) begin : g_stage
		localparam int unsigned K = W - j;
		logic [XW-1:0]        dsh;
		logic [NUM_LANES-1:0] take;

		always_comb begin
			dsh = XW'(y_s[j-1]) << K;
			for (int i = 0; i < NUM_LANES; i++) begin
				take[i] = rem_s[j-1][i] >= dsh;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (adv) begin
				vld_s[j] <= vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int i = 0; i < NUM_LANES; i++) begin
					rem_s[j][i] <= take[i] ? rem_s[j-1][i] - dsh : rem_s[j-1][i];
					q_s[j][i]   <= q_s[j-1][i] | (W'(take[i]) << K);
				end
				y_s[j]     <= y_s[j-1];
				neg_s[j]   <= neg_s[j-1];
				ovf_s[j]   <= ovf_s[j-1];
				ch_s[j]    <= ch_s[j-1];
				alpha_s[j] <= alpha_s[j-1];
				mode_s[j]  <= mode_s[j-1];
			end
		end
	end

	assign vld_o   = vld_s[W];
	assign ch_o    = ch_s[W];
	assign alpha_o = alpha_s[W];
	assign mode_o  = mode_s[W];
	assign q_o     = q_s[W];
	assign neg_o   = neg_s[W];
	assign ovf_o   = ovf_s[W];

`ifndef ASSERT_OFF
	// without range overflow the final remainder is below the divisor
	for (genvar i = 0; i < NUM_LANES; i++) begin : g_chk
		a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
			vld_s[W] && !ovf_s[W][i] |-> rem_s[W][i] < XW'(y_s[W]))
			else $error("divider remainder not below divisor");
	end

	// a zero divisor always takes the overflow path
	a_zero_div_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] && y_s[0] == '0 |-> ovf_s[0] == '1)
		else $error("zero divisor without overflow flag");

	// a stall holds the valid bit of the last stage
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s[W]))
		else $error("valid changed during stall");
`endif

endmodule

>>> hdl/luma_preserving_color_invert.sv
// top level of the luma-preserving color inversion pipeline
//
// channel   signals                                  direction
// cfg       cfg_valid, cfg_ready, cfg_data           write, one beat per register write
// in        in_valid, in_ready, red/green/blue/alpha  pixel beat in
// out       out_valid, out_ready, red/green/blue/alpha pixel beat out
//
// one pixel per cycle while the output is not stalled; the pipeline has five arithmetic
// stages, a range check, one divider stage per quotient bit and an output register.
// the per-lane divider sets the depth: it resolves one quotient bit per stage.
// reset clears all valid bits and the enable register.
// a stall at the output freezes the whole pipeline; in_ready follows it.
module luma_preserving_color_invert import lpci_pkg::*; #(
	parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [CHANNEL_BITS-1:0] red_in,
	input  logic [CHANNEL_BITS-1:0] green_in,
	input  logic [CHANNEL_BITS-1:0] blue_in,
	input  logic [CHANNEL_BITS-1:0] alpha_in,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [CHANNEL_BITS-1:0] red_out,
	output logic [CHANNEL_BITS-1:0] green_out,
	output logic [CHANNEL_BITS-1:0] blue_out,
	output logic [CHANNEL_BITS-1:0] alpha_out
);

	localparam int unsigned W = CHANNEL_BITS;
	localparam logic [W-1:0] CMAX = '1;

	logic adv;
	logic invert_enable_q;

	// pipeline moves whenever the output register is free or being drained
	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_enable_q <= 1'b0;
		end else if (cfg_valid) begin
			invert_enable_q <= cfg_data;
		end
	end

	logic [NUM_LANES-1:0][W-1:0] ch_in;
	assign ch_in = {blue_in, green_in, red_in};

	// front
	logic                        f_vld;
	logic [NUM_LANES-1:0][W-1:0] f_ch;
	logic [W-1:0]                f_alpha;
	mode_t                       f_mode;
	logic [W+1:0]                f_num, f_den, f_inv;
	logic signed [W+2:0]         f_c3 [NUM_LANES];

	lpci_front #(.CHANNEL_BITS(CHANNEL_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.vld_i(in_valid), .en_i(invert_enable_q), .ch_i(ch_in), .alpha_i(alpha_in),
		.vld_o(f_vld), .ch_o(f_ch), .alpha_o(f_alpha), .mode_o(f_mode),
		.num_o(f_num), .den_o(f_den), .inv_o(f_inv), .c3_o(f_c3)
	);

	// mix
	logic                        m_vld;
	logic [NUM_LANES-1:0][W-1:0] m_ch;
	logic [W-1:0]                m_alpha;
	mode_t                       m_mode;
	logic [2*W+6:0]              m_x [NUM_LANES];
	logic [W+4:0]                m_y;
	logic [NUM_LANES-1:0]        m_neg;

	lpci_mix #(.CHANNEL_BITS(CHANNEL_BITS)) u_mix (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.vld_i(f_vld), .ch_i(f_ch), .alpha_i(f_alpha), .mode_i(f_mode),
		.num_i(f_num), .den_i(f_den), .inv_i(f_inv), .c3_i(f_c3),
		.vld_o(m_vld), .ch_o(m_ch), .alpha_o(m_alpha), .mode_o(m_mode),
		.x_o(m_x), .y_o(m_y), .neg_o(m_neg)
	);

	// divide
	logic                        d_vld;
	logic [NUM_LANES-1:0][W-1:0] d_ch;
	logic [W-1:0]                d_alpha;
	mode_t                       d_mode;
	logic [NUM_LANES-1:0][W-1:0] d_q;
	logic [NUM_LANES-1:0]        d_neg, d_ovf;

	lpci_div #(.CHANNEL_BITS(CHANNEL_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.vld_i(m_vld), .ch_i(m_ch), .alpha_i(m_alpha), .mode_i(m_mode),
		.x_i(m_x), .y_i(m_y), .neg_i(m_neg),
		.vld_o(d_vld), .ch_o(d_ch), .alpha_o(d_alpha), .mode_o(d_mode),
		.q_o(d_q), .neg_o(d_neg), .ovf_o(d_ovf)
	);

	// final select: passthrough, grey inversion, clamp or quotient
	logic [NUM_LANES-1:0][W-1:0] res_d;
	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			if (d_mode.bypass) begin
				res_d[i] = d_ch[i];
			end else if (d_mode.grey) begin
				res_d[i] = CMAX - d_ch[i];
			end else if (d_neg[i]) begin
				res_d[i] = '0;
			end else if (d_ovf[i]) begin
				res_d[i] = CMAX;
			end else begin
				res_d[i] = d_q[i];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_out   <= res_d[0];
			green_out <= res_d[1];
			blue_out  <= res_d[2];
			alpha_out <= d_alpha;
		end
	end

`ifndef ASSERT_OFF
	// input is held back only by a beat waiting at the output
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// a beat leaving the divider while the output drains reaches the output
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		d_vld && adv |=> out_valid)
		else $error("divider beat lost at output register");

	// a stalled output keeps its beat
	a_out_keep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red_out))
		else $error("stalled output beat changed");
`endif

endmodule
